// ===== design/invertible_bloom_lookup_table_top_defines.svh =====
// Assertion macros used by the lookup table sequencer (iblt_ctrl).
// Standalone header; no dependencies.
`ifndef INVERTIBLE_BLOOM_LOOKUP_TABLE_TOP_DEFINES_SVH
`define INVERTIBLE_BLOOM_LOOKUP_TABLE_TOP_DEFINES_SVH
// check an implication on every clock edge outside reset
`define IBLT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check an implication that must also hold while reset is asserted
`define IBLT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== design/iblt_pkg.sv =====
// Shared types, codes and hash constants of the lookup table.
// No dependencies.
`timescale 1ns / 1ps
package iblt_pkg;
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_GET    = 2'd2;
	localparam logic [1:0] OP_PEEL   = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_MAYBE   = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_NO_PURE = 2'd3;

	localparam logic       CFG_CELLS  = 1'b0;
	localparam logic       CFG_PROBES = 1'b1;

	localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] FM_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FM_C2 = 64'hc4ceb9fe1a85ec53;

	typedef struct packed {
		logic        start;      // hash key/value with seed
		logic        use_value;  // hash value (len 8) instead of key
		logic [3:0]  seed;
		logic        clear;      // write zero to the cell at the scan counter
		logic        mem_wr;     // write updated cell
		logic        sel_scan;   // address from scan counter
		logic        add;        // add (else subtract)
		logic        ld_scan;    // load peel hit into key/value regs
		logic        clr_scan;
		logic        inc_scan;
	} iblt_cmd_t;

	typedef struct packed {
		logic        hash_done;
		logic        cnt_zero;
		logic        cnt_one;
		logic        key_eq;
		logic        scan_last;
		logic        clr_last;
	} iblt_stat_t;
endpackage

// ===== design/invertible_bloom_lookup_table_top.sv =====
// Per request (p probes): insert/remove hash the value, then for each probe hash the key
// and update that cell; get hashes and reads probes until an empty cell, a matching pure
// cell or the last probe; peel scans cells for a count of one and removes that pair. One
// request at a time: the next is taken once the sequencer is idle and the result accepted.
// Reset: arst_n async; a clearing pass then zeroes CELLS cells, one per cycle, before the
// first request. Config resets to 1024 cells, 3 probes. Uses iblt_pkg, iblt_ctrl, iblt_datapath.
`timescale 1ns / 1ps
module invertible_bloom_lookup_table_top
	import iblt_pkg::*;
#(
	parameter int CELLS = 1024,
	parameter int MAX_PROBES = 8,
	parameter int KEY_BYTES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // key[63:0], value[127:64]
	input  logic [1:0]   s_axis_tuser,   // opcode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // key_out[63:0], value_out[127:64]
	output logic [1:0]   m_axis_tuser,   // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int AW = $clog2(CELLS);
	logic [10:0] cells_q;
	logic [3:0]  probes_q;
	logic [AW:0] n_cells;
	logic [3:0]  n_probes;
	iblt_cmd_t   cmd;
	iblt_stat_t  stat;
	logic        busy, res_load, use_val, use_key, out_full_q;
	logic [1:0]  res_status;
	logic [63:0] key_q, val_q, rd_val;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= 11'd1024; probes_q <= 4'd3;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_CELLS) cells_q <= cfg_data[10:0];
			else probes_q <= cfg_data[3:0];
		end
	end
	always_comb begin
		if (cells_q == 11'd0) n_cells = (AW+1)'(1);
		else if ({21'd0, cells_q} > 32'(CELLS)) n_cells = (AW+1)'(CELLS);
		else n_cells = (AW+1)'(cells_q);
		if (probes_q == 4'd0) n_probes = 4'd1;
		else if ({28'd0, probes_q} > 32'(MAX_PROBES)) n_probes = 4'(MAX_PROBES);
		else n_probes = probes_q;
	end

	logic in_fire;
	assign s_axis_tready = !busy && !out_full_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	iblt_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_op(s_axis_tuser), .n_probes,
		.stat, .cmd, .busy,
		.res_load, .res_status, .res_use_val(use_val), .res_use_key(use_key)
	);

	iblt_datapath #(.CELLS(CELLS), .KEY_BYTES(KEY_BYTES)) u_dp (
		.clk, .arst_n, .in_load(in_fire),
		.in_key(s_axis_tdata[63:0]), .in_value(s_axis_tdata[127:64]),
		.n_cells, .cmd, .stat, .key_q, .val_q, .rd_val
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_full_q <= 1'b0;
		else if (res_load) out_full_q <= 1'b1;
		else if (m_axis_tready) out_full_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_load) begin
			m_axis_tuser <= res_status;
			m_axis_tdata[63:0]   <= use_key ? key_q : 64'd0;
			m_axis_tdata[127:64] <= (use_val && !use_key) ? rd_val
				: (use_key ? val_q : 64'd0);
		end
	end
	assign m_axis_tvalid = out_full_q;
endmodule

// ===== design/iblt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module iblt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== design/iblt_hash.sv =====
// Multi-cycle MurmurHash3 x64_128 second word, modulo the cell count.
// Uses iblt_pkg; one 32x32 partial product per cycle, restoring modulo.
`timescale 1ns / 1ps
module iblt_hash
	import iblt_pkg::*;
#(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   word,
	input  logic [3:0]    len,
	input  logic [3:0]    seed,
	input  logic [AW:0]   modulus,
	output logic          done,
	output logic [AW-1:0] result
);
	// microcode step
	localparam logic [4:0] S_IDLE = 5'd0, S_K1A = 5'd1, S_K1B = 5'd2, S_MIX = 5'd3,
		S_F1 = 5'd4, S_F2 = 5'd5, S_F3 = 5'd6, S_F4 = 5'd7, S_F5 = 5'd8, S_F6 = 5'd9,
		S_SUM = 5'd10, S_MOD = 5'd11, S_OUT = 5'd12;
	logic [4:0]  state_q;
	logic [63:0] h1_q, h2_q, x_q, mc_q, acc_q;
	logic [1:0]  part_q;
	logic        which_q;  // 0 fmix on h1, 1 on h2
	logic [6:0]  mbit_q;
	logic [AW:0] rem_q;
	logic        mul_busy_q;
	logic [31:0] pa, pb;
	logic [63:0] prod;
	logic [63:0] fmix_x;

	always_comb begin
		unique case (part_q)
			2'd0: begin pa = x_q[31:0];  pb = mc_q[31:0];  end
			2'd1: begin pa = x_q[31:0];  pb = mc_q[63:32]; end
			2'd2: begin pa = x_q[63:32]; pb = mc_q[31:0];  end
			default: begin pa = x_q[31:0]; pb = 32'd0; end
		endcase
	end
	assign prod   = {32'd0, pa} * {32'd0, pb};
	assign fmix_x = x_q ^ (x_q >> 33);

	logic [AW+1:0] rsh;
	assign rsh = {rem_q, h2_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			part_q     <= 2'd0;
			mul_busy_q <= 1'b0;
			which_q    <= 1'b0;
			mbit_q     <= 7'd0;
			h1_q       <= '0;
			h2_q       <= '0;
			x_q        <= '0;
			mc_q       <= '0;
			acc_q      <= '0;
			rem_q      <= '0;
		end else begin
			if (mul_busy_q) begin
				unique case (part_q)
					2'd0: acc_q <= prod;
					default: acc_q <= acc_q + {prod[31:0], 32'd0};
				endcase
				part_q <= (part_q == 2'd2) ? 2'd0 : part_q + 2'd1;
				if (part_q == 2'd2) mul_busy_q <= 1'b0;
			end else begin
				unique case (state_q)
					S_IDLE: if (start) begin
						x_q <= word; mc_q <= MM_C1; mul_busy_q <= 1'b1;
						h1_q <= {60'd0, seed}; h2_q <= {60'd0, seed};
						state_q <= S_K1A;
					end
					S_K1A: begin
						x_q <= {acc_q[32:0], acc_q[63:33]};  // rotl 31
						mc_q <= MM_C2; mul_busy_q <= 1'b1; state_q <= S_K1B;
					end
					S_K1B: begin
						h1_q <= h1_q ^ acc_q ^ {60'd0, len};
						h2_q <= h2_q ^ {60'd0, len};
						state_q <= S_MIX;
					end
					S_MIX: begin
						h1_q <= h1_q + h2_q;
						h2_q <= h2_q + h1_q + h2_q;
						x_q <= h1_q + h2_q; which_q <= 1'b0;
						state_q <= S_F1;
					end
					S_F1: begin
						x_q <= fmix_x; mc_q <= FM_C1; mul_busy_q <= 1'b1; state_q <= S_F2;
					end
					S_F2: begin x_q <= acc_q; state_q <= S_F3; end
					S_F3: begin
						x_q <= fmix_x; mc_q <= FM_C2; mul_busy_q <= 1'b1; state_q <= S_F4;
					end
					S_F4: begin x_q <= acc_q; state_q <= S_F5; end
					S_F5: begin
						if (!which_q) begin
							h1_q <= fmix_x; x_q <= h2_q; which_q <= 1'b1; state_q <= S_F1;
						end else begin
							h2_q <= fmix_x; state_q <= S_F6;
						end
					end
					S_F6: begin h1_q <= h1_q + h2_q; state_q <= S_SUM; end
					S_SUM: begin
						h2_q <= h2_q + h1_q; rem_q <= '0; mbit_q <= 7'd0;
						state_q <= S_MOD;
					end
					S_MOD: begin
						// one quotient bit per cycle
						if (rsh >= {1'b0, modulus}) rem_q <= (AW+1)'(rsh - {1'b0, modulus});
						else rem_q <= rsh[AW:0];
						h2_q <= {h2_q[62:0], 1'b0};
						mbit_q <= mbit_q + 7'd1;
						if (mbit_q == 7'd63) state_q <= S_OUT;
					end
					S_OUT: state_q <= S_IDLE;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end
	assign done   = (state_q == S_OUT);
	assign result = rem_q[AW-1:0];
endmodule

// ===== design/iblt_datapath.sv =====
// Cell memories, hash unit, operand and result registers of the lookup table.
// Uses iblt_pkg, iblt_hash and iblt_ram.
`timescale 1ns / 1ps
module iblt_datapath
	import iblt_pkg::*;
#(
	parameter int CELLS = 1024,
	parameter int KEY_BYTES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_load,
	input  logic [63:0]                 in_key,
	input  logic [63:0]                 in_value,
	input  logic [$clog2(CELLS):0]      n_cells,
	input  iblt_cmd_t                   cmd,
	output iblt_stat_t                  stat,
	output logic [63:0]                 key_q,
	output logic [63:0]                 val_q,
	output logic [63:0]                 rd_val
);
	localparam int AW = $clog2(CELLS);
	localparam logic [63:0] KMASK = (KEY_BYTES >= 8) ? {64{1'b1}}
		: ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	logic [AW-1:0] vh_q, idx_q, scan_q, addr, hres;
	logic          hdone;
	logic          we;
	logic [31:0]   rcnt;
	logic [63:0]   rkey, rvh, rsum;

	always_ff @(posedge clk) begin
		if (in_load) begin
			key_q <= in_key & KMASK;
			val_q <= in_value;
		end else if (cmd.ld_scan) begin
			key_q <= rkey;
			val_q <= rsum;
		end
		if (hdone) begin
			if (cmd.use_value) vh_q <= hres;
			else idx_q <= hres;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_q <= '0;
		else if (cmd.clr_scan) scan_q <= '0;
		else if (cmd.inc_scan) scan_q <= scan_q + AW'(1);
	end

	iblt_hash #(.AW(AW)) u_hash (
		.clk, .arst_n, .start(cmd.start),
		.word(cmd.use_value ? val_q : key_q),
		.len(cmd.use_value ? 4'd8 : 4'(KEY_BYTES)),
		.seed(cmd.seed), .modulus(n_cells), .done(hdone), .result(hres)
	);

	assign addr = cmd.sel_scan ? scan_q : idx_q;
	assign we   = cmd.mem_wr || cmd.clear;
	logic [63:0] vh64;
	assign vh64 = {{(64-AW){1'b0}}, vh_q};

	// the clearing pass after reset writes zero to every cell
	iblt_ram #(.WIDTH(32), .DEPTH(CELLS)) u_cnt (.clk, .we, .addr,
		.wdata(cmd.clear ? 32'd0 : (cmd.add ? rcnt + 32'd1 : rcnt - 32'd1)), .rdata(rcnt));
	iblt_ram #(.WIDTH(64), .DEPTH(CELLS)) u_key (.clk, .we, .addr,
		.wdata(cmd.clear ? 64'd0 : (rkey ^ key_q)), .rdata(rkey));
	iblt_ram #(.WIDTH(64), .DEPTH(CELLS)) u_vh (.clk, .we, .addr,
		.wdata(cmd.clear ? 64'd0 : (cmd.add ? rvh + vh64 : rvh - vh64)), .rdata(rvh));
	iblt_ram #(.WIDTH(64), .DEPTH(CELLS)) u_sum (.clk, .we, .addr,
		.wdata(cmd.clear ? 64'd0 : (cmd.add ? rsum + val_q : rsum - val_q)), .rdata(rsum));

	assign rd_val         = rsum;
	assign stat.hash_done = hdone;
	assign stat.cnt_zero  = (rcnt == 32'd0);
	assign stat.cnt_one   = (rcnt == 32'd1);
	assign stat.key_eq    = (rkey == key_q);
	assign stat.scan_last = ({1'b0, scan_q} == n_cells - (AW+1)'(1));
	assign stat.clr_last  = (scan_q == AW'(CELLS - 1));
endmodule

// ===== design/iblt_ctrl.sv =====
// Sequencer of the lookup table: hashing, probe loop, peel scan, clear pass.
// Uses iblt_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "invertible_bloom_lookup_table_top_defines.svh"
module iblt_ctrl
	import iblt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic [1:0]  in_op,
	input  logic [3:0]  n_probes,
	input  iblt_stat_t  stat,
	output iblt_cmd_t   cmd,
	output logic        busy,
	output logic        res_load,
	output logic [1:0]  res_status,
	output logic        res_use_val,
	output logic        res_use_key
);
	localparam logic [3:0] C_CLEAR = 4'd0, C_IDLE = 4'd1, C_VHASH = 4'd2, C_VWAIT = 4'd3,
		C_KHASH = 4'd4, C_KWAIT = 4'd5, C_RD = 4'd6, C_RDW = 4'd7, C_ACT = 4'd8,
		C_SCAN = 4'd9, C_SCW = 4'd10, C_SCT = 4'd11, C_FIN = 4'd12;
	logic [3:0] state_q;
	logic [1:0] op_q;
	logic [3:0] probe_q;
	logic       peel_q;  // removing a peeled pair

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_CLEAR; op_q <= OP_INSERT; probe_q <= '0; peel_q <= 1'b0;
		end else begin
			unique case (state_q)
				C_CLEAR: if (stat.clr_last) state_q <= C_IDLE;
				C_IDLE: if (in_fire) begin
					op_q <= in_op; probe_q <= '0; peel_q <= 1'b0;
					state_q <= (in_op == OP_GET) ? C_KHASH
						: (in_op == OP_PEEL) ? C_SCAN : C_VHASH;
				end
				C_VHASH: state_q <= C_VWAIT;
				C_VWAIT: if (stat.hash_done) state_q <= C_KHASH;
				C_KHASH: state_q <= C_KWAIT;
				C_KWAIT: if (stat.hash_done) state_q <= C_RD;
				C_RD:    state_q <= C_RDW;
				C_RDW:   state_q <= C_ACT;
				C_ACT: begin
					if (op_q == OP_GET && (stat.cnt_zero || (stat.cnt_one && stat.key_eq)))
						state_q <= C_FIN;
					else if (probe_q + 4'd1 == n_probes) state_q <= C_FIN;
					else begin probe_q <= probe_q + 4'd1; state_q <= C_KHASH; end
				end
				C_SCAN: state_q <= C_SCW;
				C_SCW:  state_q <= C_SCT;
				C_SCT: begin
					if (stat.cnt_one) begin
						peel_q <= 1'b1; op_q <= OP_REMOVE; state_q <= C_VHASH;
					end else if (stat.scan_last) state_q <= C_FIN;
					else state_q <= C_SCAN;
				end
				C_FIN:  state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.seed      = probe_q;
		cmd.add       = (op_q == OP_INSERT);
		cmd.use_value = (state_q == C_VHASH) || (state_q == C_VWAIT);
		cmd.start     = (state_q == C_VHASH) || (state_q == C_KHASH);
		cmd.clear     = (state_q == C_CLEAR);
		cmd.sel_scan  = (state_q == C_SCAN) || (state_q == C_SCW) || (state_q == C_SCT)
			|| (state_q == C_CLEAR);
		cmd.mem_wr    = (state_q == C_ACT) && (op_q != OP_GET);
		cmd.ld_scan   = (state_q == C_SCT) && stat.cnt_one;
		cmd.clr_scan  = (state_q == C_IDLE);
		cmd.inc_scan  = ((state_q == C_SCT) && !stat.cnt_one) || (state_q == C_CLEAR);
	end

	assign busy     = (state_q != C_IDLE);

	// result capture
	always_comb begin
		res_load = 1'b0; res_status = ST_DONE; res_use_val = 1'b0; res_use_key = 1'b0;
		if (state_q == C_ACT && op_q == OP_GET) begin
			if (stat.cnt_zero) begin
				res_load = 1'b1; res_status = ST_ABSENT;
			end else if (stat.cnt_one && stat.key_eq) begin
				res_load = 1'b1; res_status = ST_DONE; res_use_val = 1'b1;
			end else if (probe_q + 4'd1 == n_probes) begin
				res_load = 1'b1; res_status = ST_MAYBE;
			end
		end else if (state_q == C_ACT && probe_q + 4'd1 == n_probes) begin
			res_load = 1'b1; res_status = ST_DONE;
			res_use_val = peel_q; res_use_key = peel_q;
		end else if (state_q == C_SCT && !stat.cnt_one && stat.scan_last) begin
			res_load = 1'b1; res_status = ST_NO_PURE;
		end
	end

	`IBLT_ASSERT(a_no_write_get, cmd.mem_wr |-> op_q != OP_GET, "write during get")
	`IBLT_ASSERT(a_res_once, res_load |=> !res_load, "result loaded twice")
	`IBLT_ASSERT(a_busy_fire, in_fire |-> !busy, "request taken while busy")
	`IBLT_ASSERT_ALWAYS(a_probe_rng, !arst_n || probe_q <= 4'd15, "probe index range")
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for invertible_bloom_lookup_table_top: table-driven directed
// requests, then random request streams under several table sizes and probe counts.
// Depends on iblt_pkg and the top-level RTL.
`timescale 1ns / 1ps
module tb
	import iblt_pkg::*;
();

	localparam int NCELLS = 1024;
	localparam int NPROBES = 8;

	typedef struct packed {
		logic [1:0]  st;
		logic [63:0] k;
		logic [63:0] v;
	} res_t;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] key;
		logic [63:0] val;
		bit          fixed;
		res_t        res;
	} row_t;

	typedef struct {
		logic [63:0] key;
		logic [63:0] val;
	} pair_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	// mirror of the table contents and registers
	logic [31:0] cnt_m [NCELLS];
	logic [63:0] kxor_m [NCELLS];
	logic [63:0] vhash_m [NCELLS];
	logic [63:0] vsum_m [NCELLS];
	logic [10:0] cells_reg;
	logic [3:0]  probes_reg;

	res_t  pending_results [$];
	pair_t live_pairs [$];
	int    errors;
	bit    quiet;

	invertible_bloom_lookup_table_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [63:0] mix_final(logic [63:0] k);
		k ^= k >> 33;
		k = k * FM_C1;
		k ^= k >> 33;
		k = k * FM_C2;
		k ^= k >> 33;
		return k;
	endfunction

	// upper 64 bits of the 128-bit murmur digest for a single block message
	function automatic logic [63:0] murmur_hi(logic [63:0] w, logic [63:0] len,
			logic [63:0] seed);
		logic [63:0] h1, h2, k1;
		h1 = seed;
		h2 = seed;
		k1 = w * MM_C1;
		k1 = {k1[32:0], k1[63:33]};
		k1 = k1 * MM_C2;
		h1 ^= k1;
		h1 ^= len;
		h2 ^= len;
		h1 += h2;
		h2 += h1;
		h1 = mix_final(h1);
		h2 = mix_final(h2);
		h1 += h2;
		h2 += h1;
		return h2;
	endfunction

	function automatic int n_cells();
		if (cells_reg == 0) return 1;
		if (cells_reg > NCELLS) return NCELLS;
		return int'(cells_reg);
	endfunction

	function automatic int n_probes();
		if (probes_reg == 0) return 1;
		if (probes_reg > NPROBES) return NPROBES;
		return int'(probes_reg);
	endfunction

	function automatic int cell_idx(logic [63:0] key, int p);
		return int'(murmur_hi(key, 64'd8, 64'(p)) % 64'(n_cells()));
	endfunction

	function automatic void update_cells(logic [63:0] key, logic [63:0] val, bit add);
		logic [63:0] vh;
		int c;
		vh = murmur_hi(val, 64'd8, 64'd1) % 64'(n_cells());
		for (int p = 0; p < n_probes(); p++) begin
			c = cell_idx(key, p);
			kxor_m[c] ^= key;
			if (add) begin
				cnt_m[c] += 1;
				vhash_m[c] += vh;
				vsum_m[c] += val;
			end else begin
				cnt_m[c] -= 1;
				vhash_m[c] -= vh;
				vsum_m[c] -= val;
			end
		end
	endfunction

	function automatic res_t table_step(logic [1:0] op, logic [63:0] key, logic [63:0] val);
		res_t r;
		int c;
		r = '0;
		case (op)
			OP_INSERT: update_cells(key, val, 1'b1);
			OP_REMOVE: update_cells(key, val, 1'b0);
			OP_GET: begin
				r.st = ST_MAYBE;
				for (int p = 0; p < n_probes(); p++) begin
					c = cell_idx(key, p);
					if (cnt_m[c] == 0) begin
						r.st = ST_ABSENT;
						break;
					end
					if (cnt_m[c] == 1 && kxor_m[c] == key) begin
						r.st = ST_DONE;
						r.v = vsum_m[c];
						break;
					end
				end
			end
			default: begin
				r.st = ST_NO_PURE;
				for (int i = 0; i < n_cells(); i++) begin
					if (cnt_m[i] == 1) begin
						r.st = ST_DONE;
						r.k = kxor_m[i];
						r.v = vsum_m[i];
						update_cells(r.k, r.v, 1'b0);
						break;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_request(logic [1:0] op, logic [63:0] key, logic [63:0] val,
			bit fixed, res_t fixed_res);
		int gap;
		res_t r;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {val, key};
		s_axis_tuser <= op;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		r = table_step(op, key, val);
		pending_results.insert(pending_results.size(), fixed ? fixed_res : r);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] d);
		drain();
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_CELLS) cells_reg = d[10:0];
		else probes_reg = d[3:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 9))
			0: return 64'h7fffffffffffffff;
			1: return 64'h8000000000000000;
			2: return '1;
			3: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		res_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result st=%0d data=%h", $realtime, m_axis_tuser,
					m_axis_tdata);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_axis_tuser !== e.st) begin
					$display("%0t: status exp %0d got %0d", $realtime, e.st, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[63:0] !== e.k) begin
					$display("%0t: key_out exp %h got %h", $realtime, e.k,
						m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[127:64] !== e.v) begin
					$display("%0t: value_out exp %h got %h", $realtime, e.v,
						m_axis_tdata[127:64]);
					errors++;
				end
			end
		end
	end

	// result sink with random stalls
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = quiet ? 0 : $urandom_range(0, 6);
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	row_t dir_rows [16];
	int   phase_cells [8] = '{1, 2047, 0, 16, 64, 37, 1024, 200};
	int   phase_probes [8] = '{1, 15, 0, 8, 3, 2, 8, 5};
	int   phase_items [8] = '{80, 150, 80, 250, 300, 250, 150, 240};

	initial begin
		logic [63:0] k, v;
		int idx, sel;
		errors = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_INSERT;
		cfg_valid = 1'b0;
		cfg_index = CFG_CELLS;
		cfg_data = '0;
		cells_reg = 11'd1024;
		probes_reg = 4'd3;
		for (int i = 0; i < NCELLS; i++) begin
			cnt_m[i] = '0;
			kxor_m[i] = '0;
			vhash_m[i] = '0;
			vsum_m[i] = '0;
		end
		dir_rows = '{
			'{OP_GET, 64'd0, 64'd5, 1, '{ST_ABSENT, 64'd0, 64'd0}},
			'{OP_PEEL, '1, '1, 1, '{ST_NO_PURE, 64'd0, 64'd0}},
			'{OP_INSERT, '1, 64'h7fffffffffffffff, 1, '{ST_DONE, 64'd0, 64'd0}},
			'{OP_INSERT, 64'd0, 64'h8000000000000000, 1, '{ST_DONE, 64'd0, 64'd0}},
			'{OP_GET, '1, 64'd0, 0, '0},
			'{OP_GET, 64'd0, '1, 0, '0},
			'{OP_GET, 64'h0123456789abcdef, 64'd0, 0, '0},
			'{OP_REMOVE, 64'd0, 64'h8000000000000000, 1, '{ST_DONE, 64'd0, 64'd0}},
			'{OP_PEEL, 64'd0, 64'd0, 0, '0},
			'{OP_PEEL, 64'd0, 64'd0, 1, '{ST_NO_PURE, 64'd0, 64'd0}},
			'{OP_INSERT, 64'h5555aaaa5555aaaa, 64'd7, 0, '0},
			'{OP_INSERT, 64'h5555aaaa5555aaaa, 64'd9, 0, '0},
			'{OP_GET, 64'h5555aaaa5555aaaa, 64'd0, 0, '0},
			'{OP_REMOVE, 64'h5555aaaa5555aaaa, 64'd7, 0, '0},
			'{OP_GET, 64'h5555aaaa5555aaaa, 64'd0, 0, '0},
			'{OP_PEEL, 64'd0, 64'd0, 0, '0}
		};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val,
				dir_rows[i].fixed, dir_rows[i].res);

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_CELLS, {21'($urandom_range(0, 2097151)), phase_cells[ph][10:0]});
			write_reg(CFG_PROBES, {8'($urandom_range(0, 255)), 20'h0, phase_probes[ph][3:0]});
			quiet = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < phase_items[ph]; n++) begin
				if (ph == 4 && n == 120) drain();
				sel = $urandom_range(0, 99);
				if (sel < 40 || live_pairs.size() == 0) begin
					k = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 15)) : rand64();
					v = rand64();
					live_pairs.insert(live_pairs.size(), '{k, v});
					send_request(OP_INSERT, k, v, 0, '0);
				end else if (sel < 60) begin
					idx = $urandom_range(0, live_pairs.size() - 1);
					send_request(OP_REMOVE, live_pairs[idx].key, live_pairs[idx].val, 0, '0);
					live_pairs.delete(idx);
				end else if (sel < 80) begin
					idx = $urandom_range(0, live_pairs.size() - 1);
					k = ($urandom_range(0, 2) == 0) ? rand64() : live_pairs[idx].key;
					send_request(OP_GET, k, rand64(), 0, '0);
				end else if (sel < 95) begin
					send_request(OP_PEEL, rand64(), rand64(), 0, '0);
				end else begin
					// unmatched removal drives counts negative
					send_request(OP_REMOVE, rand64(), rand64(), 0, '0);
				end
			end
		end
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
